FILE: rtl/dfl_pkg.sv
// types and constants shared by the descriptor free list
package dfl_pkg;

  localparam int unsigned LINK_W  = 9;
  localparam int unsigned DESC_W  = 16;
  localparam int unsigned GRANT_W = 8;

  // link value that terminates the free list
  localparam logic [LINK_W-1:0] END_MARK     = 9'd256;
  localparam logic [DESC_W-1:0] INVALID_DESC = 16'hFFFF;
  // largest supported queue size
  localparam logic [LINK_W-1:0] MAX_SIZE     = 9'd256;

  typedef enum logic [1:0] {
    FN_INIT  = 2'd0,
    FN_ALLOC = 2'd1,
    FN_FREE  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    func_t             func;
    logic [DESC_W-1:0] desc_index;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [GRANT_W-1:0] granted_index;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_INIT
  } state_t;

endpackage

FILE: rtl/descriptor_free_list.sv
// descriptor free list: linked stack of free descriptor indices in one memory
//
// request channel (req_valid / req_stall / req) carries one operation per
// beat: init chains entries 0..size-1, allocate pops the head, free pushes
// an index. every request beat produces exactly one response beat on
// rsp_valid / rsp_stall / rsp, registered in the cycle after the request beat.
// the pool size register is written through cfg_wr_en / cfg_wr_data; the
// user must write it only while the block is idle; the block does not
// enforce this. it is saturated to 1..min(QUEUE_DEPTH, 256) when used. a
// free needs no extra state, an allocate uses S_ALLOC for a synchronous read
// of the new head, and an init writes one entry a cycle in S_INIT.
// reset empties the list (head at the end marker) and sets the pool size to
// 256; link memory contents are not cleared, and an init must come first.
// if the receiver stalls, the response stays in the output register and a
// new request is taken as soon as that register drains in the same cycle.
module descriptor_free_list #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  dfl_pkg::req_t            req,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output dfl_pkg::rsp_t            rsp,
  input  logic                     cfg_wr_en,
  input  logic [dfl_pkg::LINK_W-1:0] cfg_wr_data
);
  import dfl_pkg::*;

  // only the first min(depth, 256) entries can ever be linked
  localparam int CAP   = (QUEUE_DEPTH < 256) ? QUEUE_DEPTH : 256;
  localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
  localparam logic [LINK_W-1:0] CAP_SIZE = LINK_W'(CAP);

  // link memory, one entry per descriptor
  logic [LINK_W-1:0] link_mem [CAP];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [LINK_W-1:0] mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [LINK_W-1:0] rd_data;

  // control and state registers
  state_t            state, state_next;
  logic [LINK_W-1:0] head, head_next;
  logic [LINK_W-1:0] pool_size;
  logic [IDX_W-1:0]  init_cnt, init_cnt_next;
  logic [IDX_W-1:0]  init_last, init_last_next;
  logic              rsp_valid_next;
  rsp_t              rsp_next;

  logic              accept;
  logic [LINK_W-1:0] size_eff;
  logic              head_empty;
  logic              free_bad;

  // size in effect, saturated to the supported range
  always_comb begin
    if (pool_size == '0) begin
      size_eff = LINK_W'(1);
    end else if (pool_size > CAP_SIZE) begin
      size_eff = CAP_SIZE;
    end else begin
      size_eff = pool_size;
    end
  end

  assign head_empty = (head == END_MARK) || (32'(head) >= 32'(QUEUE_DEPTH));
  assign free_bad   = (req.desc_index == INVALID_DESC) ||
                      (req.desc_index >= DESC_W'(size_eff));

  // a request is taken only when idle and the response register is free
  // or draining this cycle
  assign req_stall = (state != S_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;

  always_comb begin
    state_next     = state;
    head_next      = head;
    init_cnt_next  = init_cnt;
    init_last_next = init_last;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = head[IDX_W-1:0];

    case (state)
      S_IDLE: begin
        if (accept) begin
          // every operation answers in the cycle after its beat
          rsp_valid_next         = 1'b1;
          rsp_next.status        = ST_OK;
          rsp_next.granted_index = '0;
          case (req.func)
            FN_INIT: begin
              // head goes to entry 0, links are swept in afterwards
              head_next      = '0;
              init_cnt_next  = '0;
              init_last_next = IDX_W'(size_eff - LINK_W'(1));
              state_next     = S_INIT;
            end
            FN_ALLOC: begin
              if (head_empty) begin
                rsp_next.status = ST_EMPTY;
              end else begin
                // hand out the head now, fetch its link for the new head
                rsp_next.granted_index = head[GRANT_W-1:0];
                mem_re                 = 1'b1;
                state_next             = S_ALLOC;
              end
            end
            FN_FREE: begin
              if (free_bad) begin
                rsp_next.status = ST_INVALID;
              end else begin
                // push: freed entry links to the old head
                mem_we    = 1'b1;
                mem_waddr = req.desc_index[IDX_W-1:0];
                mem_wdata = head;
                head_next = LINK_W'(req.desc_index);
              end
            end
            default: begin
              // unused operation code, answered with no effect
            end
          endcase
        end
      end
      S_ALLOC: begin
        // link read back from memory becomes the head
        head_next  = rd_data;
        state_next = S_IDLE;
      end
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_cnt;
        if (init_cnt == init_last) begin
          mem_wdata  = END_MARK;
          state_next = S_IDLE;
        end else begin
          mem_wdata     = LINK_W'(init_cnt) + LINK_W'(1);
          init_cnt_next = init_cnt + IDX_W'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= END_MARK;
      pool_size  <= MAX_SIZE;
      rsp_valid  <= 1'b0;
      init_cnt   <= '0;
      init_last  <= '0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      rsp_valid <= rsp_valid_next;
      init_cnt  <= init_cnt_next;
      init_last <= init_last_next;
      if (cfg_wr_en) begin
        pool_size <= cfg_wr_data;
      end
    end
  end

  // response payload, no reset needed
  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

  // link memory with one write port and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= link_mem[mem_raddr];
    end
  end

endmodule

FILE: dv/tb_descriptor_free_list.sv
// testbench for the descriptor free list: directed and random alloc/free/init beats checked
`timescale 1ns / 100ps

module tb_descriptor_free_list;
  import dfl_pkg::*;

  localparam int DEPTH = 256;
  // cycles with no beat on either channel before the run is called hung
  localparam int HANG_LIMIT = 20000;
  // func code that the block must ignore
  localparam logic [1:0] FN_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  req_t                req = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  rsp_t                rsp;
  logic                cfg_wr_en = 1'b0;
  logic [LINK_W-1:0]   cfg_wr_data = '0;

  // mirror of the list state, advanced on every accepted request beat
  logic [LINK_W-1:0]   mdl_head;
  logic [LINK_W-1:0]   mdl_link [DEPTH];
  logic [LINK_W-1:0]   mdl_size;
  rsp_t                expected_rsp [$];
  rsp_t                oldest_rsp;
  // descriptors currently handed out, so frees can return real ones
  logic [GRANT_W-1:0]  held_descs [$];

  int                  items_sent = 0;
  int                  results_seen = 0;
  int                  err_count = 0;
  int                  quiet_cycles = 0;
  int unsigned         snd_pct = 0;
  int unsigned         rcv_pct = 0;
  int                  hold_cycles = 0;

  always #5 clk = ~clk;

  descriptor_free_list #(
    .QUEUE_DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // pool size as the block uses it: clamped to 1..min(depth, 256)
  function automatic int unsigned active_size();
    int unsigned cap;
    int unsigned s;
    cap = (DEPTH < 256) ? DEPTH : 256;
    s = mdl_size;
    if (s < 1) s = 1;
    if (s > cap) s = cap;
    return s;
  endfunction

  // one request beat applied to the mirrored list; returns the response it must cause
  function automatic rsp_t free_list_step(input req_t r);
    rsp_t        o;
    int unsigned n;
    int unsigned i;
    o.status = ST_OK;
    o.granted_index = '0;
    case (r.func)
      FN_INIT: begin
        n = active_size();
        for (i = 0; i + 1 < n; i++) mdl_link[i] = LINK_W'(i + 1);
        mdl_link[n-1] = END_MARK;
        mdl_head = '0;
        held_descs.delete();
      end
      FN_ALLOC: begin
        // end marker or a head past storage both read as empty
        if (mdl_head == END_MARK || mdl_head >= DEPTH) begin
          o.status = ST_EMPTY;
        end else begin
          o.granted_index = mdl_head[GRANT_W-1:0];
          held_descs.push_back(mdl_head[GRANT_W-1:0]);
          mdl_head = mdl_link[mdl_head[GRANT_W-1:0]];
        end
      end
      FN_FREE: begin
        // sentinel and indexes past the pool are dropped, double frees are not caught
        if (r.desc_index == INVALID_DESC || r.desc_index >= active_size()) begin
          o.status = ST_INVALID;
        end else begin
          mdl_link[r.desc_index[GRANT_W-1:0]] = mdl_head;
          mdl_head = r.desc_index[LINK_W-1:0];
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic req_t req_of(input logic [1:0] f, input logic [DESC_W-1:0] d);
    req_t r;
    r.func = func_t'(f);
    r.desc_index = d;
    return r;
  endfunction

  // random beat: mostly allocs and frees of held descriptors, the rest noise
  function automatic req_t pick_item();
    req_t        r;
    int unsigned roll;
    int unsigned k;
    r.func = FN_ALLOC;
    r.desc_index = DESC_W'($urandom);
    roll = $urandom_range(99);
    if (roll < 3) begin
      r.func = FN_INIT;
    end else if (roll < 48) begin
      r.func = FN_ALLOC;
    end else if (roll < 80) begin
      // falls back to an alloc when nothing is held
      if (held_descs.size() != 0) begin
        k = $urandom_range(held_descs.size() - 1);
        r.func = FN_FREE;
        r.desc_index = DESC_W'(held_descs[k]);
        held_descs.delete(k);
      end
    end else if (roll < 86) begin
      // any index in the pool, often a double free
      r.func = FN_FREE;
      r.desc_index = DESC_W'($urandom_range(active_size() - 1));
    end else if (roll < 90) begin
      r.func = FN_FREE;
      r.desc_index = INVALID_DESC;
    end else if (roll < 93) begin
      // first index past the pool
      r.func = FN_FREE;
      r.desc_index = DESC_W'(active_size());
    end else if (roll < 97) begin
      r.func = FN_FREE;
    end else begin
      r.func = func_t'(FN_UNUSED);
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int want, input int got);
    err_count++;
    $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
  endtask

  // drive one request beat, with random sender gaps, and wait until it is taken
  task automatic send_req(input req_t r);
    if (snd_pct != 0 && $urandom_range(99) < snd_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_pct);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    items_sent++;
  endtask

  // stop offering beats and wait until every response has come back
  task automatic settle_outstanding();
    req_valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
  endtask

  // register write only once the block is idle and ready again
  task automatic set_queue_size(input logic [LINK_W-1:0] v);
    settle_outstanding();
    while (req_stall) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // list starts empty after reset; a free before any init is still a push
  task automatic test_before_init();
    send_req(req_of(FN_ALLOC, 16'd0));
    send_req(req_of(FN_FREE, INVALID_DESC));
    send_req(req_of(FN_FREE, 16'd256));
    send_req(req_of(FN_FREE, 16'h8000));
    send_req(req_of(FN_FREE, 16'hFFFE));
    send_req(req_of(FN_UNUSED, 16'h1234));
    send_req(req_of(FN_FREE, 16'd5));
    send_req(req_of(FN_ALLOC, 16'd0));
    send_req(req_of(FN_ALLOC, 16'd0));
  endtask

  // oversize register clamps to the full pool; top index and a double free
  task automatic test_full_pool();
    set_queue_size(9'd511);
    send_req(req_of(FN_INIT, 16'd0));
    send_req(req_of(FN_ALLOC, 16'd0));
    send_req(req_of(FN_ALLOC, 16'd0));
    send_req(req_of(FN_FREE, 16'd255));
    send_req(req_of(FN_ALLOC, 16'd0));
    send_req(req_of(FN_FREE, 16'd1));
    send_req(req_of(FN_FREE, 16'd1));
    send_req(req_of(FN_ALLOC, 16'd0));
    send_req(req_of(FN_ALLOC, 16'd0));
    send_req(req_of(FN_ALLOC, 16'd0));
  endtask

  // zero size clamps to one descriptor
  task automatic test_min_size();
    set_queue_size(9'd0);
    send_req(req_of(FN_INIT, 16'd0));
    send_req(req_of(FN_ALLOC, 16'd0));
    send_req(req_of(FN_ALLOC, 16'd0));
    send_req(req_of(FN_FREE, 16'd1));
    send_req(req_of(FN_FREE, 16'd0));
    send_req(req_of(FN_ALLOC, 16'd0));
  endtask

  // long receiver hold-off fills the output register and stalls the request side
  task automatic test_backpressure();
    snd_pct = 0;
    rcv_pct = 0;
    set_queue_size(9'd6);
    send_req(req_of(FN_INIT, 16'd0));
    hold_cycles = 300;
    repeat (30) send_req(pick_item());
    // sender waits out every response before going on
    settle_outstanding();
  endtask

  task automatic test_random_mix(input logic [LINK_W-1:0] size, input int unsigned s_pct,
                                 input int unsigned r_pct, input int count);
    set_queue_size(size);
    snd_pct = s_pct;
    rcv_pct = r_pct;
    send_req(req_of(FN_INIT, 16'd0));
    repeat (count) send_req(pick_item());
  endtask

  // receiver stall, random or held for a counted stretch
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      rsp_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < rcv_pct);
    end
  end

  // check the response beat first, then record what the new request beat must cause
  always @(posedge clk) begin
    if (rst) begin
      mdl_head = END_MARK;
      mdl_size = MAX_SIZE;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (expected_rsp.size() == 0) begin
          flag_mismatch("response beat with nothing expected", 0, 0);
        end else begin
          oldest_rsp = expected_rsp.pop_front();
          if (rsp.status !== oldest_rsp.status)
            flag_mismatch("status", oldest_rsp.status, rsp.status);
          if (rsp.granted_index !== oldest_rsp.granted_index)
            flag_mismatch("granted_index", oldest_rsp.granted_index, rsp.granted_index);
        end
      end
      if (req_valid && !req_stall) expected_rsp.push_back(free_list_step(req));
      if (cfg_wr_en) mdl_size = cfg_wr_data;
    end
  end

  // hang detector: any beat on either channel or a register write restarts the count
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("descriptor_free_list test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_before_init();
    test_full_pool();
    test_min_size();
    test_backpressure();

    // no idling, then sender gaps, receiver stalls, and both together
    test_random_mix(9'd4, 0, 0, 210);
    test_random_mix(9'd511, 0, 0, 210);
    test_random_mix(9'd0, 77, 0, 210);
    test_random_mix(9'd13, 77, 0, 210);
    test_random_mix(9'd1, 0, 77, 210);
    test_random_mix(LINK_W'($urandom_range(2, 32)), 0, 77, 210);
    test_random_mix(9'd256, 13, 13, 210);
    test_random_mix(LINK_W'($urandom_range(0, 511)), 13, 13, 210);

    settle_outstanding();
    // then idle to catch stray response beats
    repeat (20) @(posedge clk);
    if (expected_rsp.size() != 0)
      flag_mismatch("responses left over", expected_rsp.size(), 0);
    if (err_count == 0) begin
      $display("descriptor_free_list test passed");
    end else begin
      $display("descriptor_free_list test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/dfl_pkg.sv
rtl/descriptor_free_list.sv
dv/tb_descriptor_free_list.sv
